>>> design/fixed_point_dense_layer_mac_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the dense layer MAC core
// Shared concurrent checks, clocked on the rising edge, off during reset.
// ----------------------------------------------------------------------------
`ifndef FIXED_POINT_DENSE_LAYER_MAC_CORE_DEFINES_SVH
`define FIXED_POINT_DENSE_LAYER_MAC_CORE_DEFINES_SVH

// Condition must hold at every clock edge out of reset
`define FPDL_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define FPDL_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> design/fpdl_pkg.sv
// ----------------------------------------------------------------------------
// fpdl_pkg
// Sizes, codes and shared types of the fixed-point dense layer MAC core.
// ----------------------------------------------------------------------------
package fpdl_pkg;

    localparam int MAX_INPUTS  = 1024;
    localparam int MAX_OUTPUTS = 16;
    localparam int DATA_WIDTH  = 16;

    localparam int IN_W    = $clog2(MAX_INPUTS) + 1;     // in_size register
    localparam int OUT_W   = $clog2(MAX_OUTPUTS) + 1;    // out_size register
    localparam int NEU_W   = 4;                          // neuron field
    localparam int FRAC_W  = 4;
    localparam int IDX_W   = 14;
    localparam int ACT_AW  = $clog2(MAX_INPUTS);
    localparam int BIAS_AW = $clog2(MAX_OUTPUTS);
    localparam int W_AW    = IDX_W;
    localparam int W_DEPTH = MAX_INPUTS * MAX_OUTPUTS;
    localparam int ACC_W   = 48;
    localparam int PROD_W  = 2 * DATA_WIDTH;
    localparam int CFG_W   = IN_W;

    // command queue between front and back
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH) + 1;

    // request codes
    localparam logic [1:0] OP_LD_W   = 2'd0;
    localparam logic [1:0] OP_LD_B   = 2'd1;
    localparam logic [1:0] OP_LD_A   = 2'd2;
    localparam logic [1:0] OP_START  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_IN_SIZE   = 2'd0;
    localparam logic [1:0] CFG_OUT_SIZE  = 2'd1;
    localparam logic [1:0] CFG_FRAC_BITS = 2'd2;
    localparam logic [1:0] CFG_RELU      = 2'd3;

    // configuration reset values
    localparam logic [IN_W-1:0]   RST_IN_SIZE   = IN_W'(784);
    localparam logic [OUT_W-1:0]  RST_OUT_SIZE  = OUT_W'(10);
    localparam logic [FRAC_W-1:0] RST_FRAC_BITS = FRAC_W'(8);

    // saturation bounds of the signed data range
    localparam logic signed [ACC_W-1:0] SAT_MAX =
        ACC_W'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] SAT_MIN = -SAT_MAX - ACC_W'(1);

    typedef struct packed {
        logic [1:0]                   op;
        logic [IDX_W-1:0]             index;
        logic signed [DATA_WIDTH-1:0] value;
    } t_cmd;

    typedef struct packed {
        logic [IN_W-1:0]   in_size;
        logic [OUT_W-1:0]  out_size;
        logic [FRAC_W-1:0] frac_bits;
        logic              relu;
    } t_cfg;

    typedef struct packed {
        logic [OUT_W-1:0] no;      // neuron count of the running start
        logic             relu;    // ReLU mode of the running start
    } t_back_stat;

    typedef struct packed {
        logic [QCNT_W-1:0] level;
    } t_q_stat;

endpackage

>>> design/fixed_point_dense_layer_mac_core.sv
// ----------------------------------------------------------------------------
// fixed_point_dense_layer_mac_core
// Fixed-point fully connected layer with load, start and result channels.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (i_valid / o_ready): each transfer carries a request
//   type, an index and a signed 16-bit value. Weight, bias and activation
//   loads are taken one per cycle while the queue has room; loads aimed outside a store are dropped.
//   A start transfer computes out_size neurons over in_size activations.
//   Result channel (o_valid / i_ready): one transfer per neuron, in neuron
//   order, o_last set on the final one.
//   A start runs, per neuron, bias setup, one MAC per cycle from the weight
//   and activation memory read ports, a pipeline drain and saturation.
//   A start waits until the previous result has left the output register.
//   A four-entry queue between the input stage and the engine keeps
//   requests flowing while a layer runs; when the receiver stalls, the
//   result holds in the output register and the engine waits.
//   Reset clears control state and restores the configuration defaults;
//   store contents are undefined until written and need no clearing pass.
//   Configuration writes are single-cycle and only legal while idle.
// ----------------------------------------------------------------------------
`include "fixed_point_dense_layer_mac_core_defines.svh"

module fixed_point_dense_layer_mac_core (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_wr_en,
    input  logic [1:0]                             i_cfg_index,
    input  logic [fpdl_pkg::CFG_W-1:0]             i_cfg_data,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic [1:0]                             i_req_type,
    input  logic [fpdl_pkg::IDX_W-1:0]             i_index,
    input  logic signed [fpdl_pkg::DATA_WIDTH-1:0] i_value,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic [fpdl_pkg::NEU_W-1:0]             o_neuron,
    output logic signed [fpdl_pkg::DATA_WIDTH-1:0] o_result,
    output logic                                   o_last
);

    fpdl_pkg::t_cfg        r_cfg;
    fpdl_pkg::t_cmd        front_cmd;
    fpdl_pkg::t_cmd        q_cmd;
    fpdl_pkg::t_q_stat     q_stat;
    fpdl_pkg::t_back_stat  back_stat;
    logic                  front_valid;
    logic                  front_ready;
    logic                  q_valid;
    logic                  q_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.in_size   <= fpdl_pkg::RST_IN_SIZE;
            r_cfg.out_size  <= fpdl_pkg::RST_OUT_SIZE;
            r_cfg.frac_bits <= fpdl_pkg::RST_FRAC_BITS;
            r_cfg.relu      <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                fpdl_pkg::CFG_IN_SIZE:   r_cfg.in_size   <= i_cfg_data;
                fpdl_pkg::CFG_OUT_SIZE:  r_cfg.out_size  <= i_cfg_data[fpdl_pkg::OUT_W-1:0];
                fpdl_pkg::CFG_FRAC_BITS: r_cfg.frac_bits <= i_cfg_data[fpdl_pkg::FRAC_W-1:0];
                fpdl_pkg::CFG_RELU:      r_cfg.relu      <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    fpdl_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_req_type  (i_req_type),
        .i_index     (i_index),
        .i_value     (i_value),
        .o_cmd_valid (front_valid),
        .i_cmd_ready (front_ready),
        .o_cmd       (front_cmd)
    );

    fpdl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (front_ready),
        .i_cmd   (front_cmd),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_cmd   (q_cmd),
        .o_stat  (q_stat)
    );

    fpdl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (q_valid),
        .o_cmd_ready (q_ready),
        .i_cmd       (q_cmd),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_neuron    (o_neuron),
        .o_result    (o_result),
        .o_last      (o_last),
        .o_stat      (back_stat)
    );

    // queue never fills past its depth
    `FPDL_ASSERT_ALWAYS(a_q_level, i_clk, i_rst_n, q_stat.level <= fpdl_pkg::QCNT_W'(fpdl_pkg::QDEPTH), "queue level above depth")
    // last result belongs to the final neuron of the running start
    `FPDL_ASSERT_IMPLY(a_last_neuron, i_clk, i_rst_n, o_valid && o_last, ({1'b0, o_neuron} + fpdl_pkg::OUT_W'(1)) == back_stat.no, "last flag on wrong neuron")
    // results never pass the neuron count
    `FPDL_ASSERT_IMPLY(a_neuron_range, i_clk, i_rst_n, o_valid, ({1'b0, o_neuron} < back_stat.no), "result neuron beyond count")
    // ReLU mode never emits a negative result
    `FPDL_ASSERT_IMPLY(a_relu_sign, i_clk, i_rst_n, o_valid && back_stat.relu, !o_result[fpdl_pkg::DATA_WIDTH-1], "negative result in ReLU mode")

endmodule

>>> design/fpdl_front.sv
// ----------------------------------------------------------------------------
// fpdl_front
// Input stage: takes request transfers, drops loads aimed outside the
// stores and holds one classified command for the queue.
// ----------------------------------------------------------------------------
module fpdl_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [1:0]                           i_req_type,
    input  logic [fpdl_pkg::IDX_W-1:0]           i_index,
    input  logic signed [fpdl_pkg::DATA_WIDTH-1:0] i_value,
    output logic                                 o_cmd_valid,
    input  logic                                 i_cmd_ready,
    output fpdl_pkg::t_cmd                       o_cmd
);

    logic           r_valid;
    logic           n_valid;
    fpdl_pkg::t_cmd r_cmd;
    logic           accept;
    logic           keep;

    assign o_ready     = !r_valid || i_cmd_ready;
    assign accept      = i_valid && o_ready;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    // classify: keep starts and loads whose index lands in a store
    always_comb begin
        case (i_req_type)
            fpdl_pkg::OP_LD_W:  keep = 1'b1;
            fpdl_pkg::OP_LD_B:  keep = (i_index < fpdl_pkg::IDX_W'(fpdl_pkg::MAX_OUTPUTS));
            fpdl_pkg::OP_LD_A:  keep = (i_index < fpdl_pkg::IDX_W'(fpdl_pkg::MAX_INPUTS));
            fpdl_pkg::OP_START: keep = 1'b1;
            default:            keep = 1'b0;
        endcase
    end

    // hold the command until the queue takes it
    always_comb begin
        if (accept) begin
            n_valid = keep;
        end else begin
            n_valid = r_valid && !i_cmd_ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd.op    <= i_req_type;
            r_cmd.index <= i_index;
            r_cmd.value <= i_value;
        end
    end

endmodule

>>> design/fpdl_queue.sv
// ----------------------------------------------------------------------------
// fpdl_queue
// Short command FIFO between the input stage and the execution engine.
// ----------------------------------------------------------------------------
module fpdl_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  fpdl_pkg::t_cmd     i_cmd,
    output logic               o_valid,
    input  logic               i_ready,
    output fpdl_pkg::t_cmd     o_cmd,
    output fpdl_pkg::t_q_stat  o_stat
);

    fpdl_pkg::t_cmd                  r_mem [0:fpdl_pkg::QDEPTH-1];
    logic [fpdl_pkg::QPTR_W-1:0]     r_wr_ptr;
    logic [fpdl_pkg::QPTR_W-1:0]     r_rd_ptr;
    logic [fpdl_pkg::QCNT_W-1:0]     r_count;
    logic                            push;
    logic                            pop;

    assign o_ready      = (r_count != fpdl_pkg::QCNT_W'(fpdl_pkg::QDEPTH));
    assign o_valid      = (r_count != '0);
    assign push         = i_valid && o_ready;
    assign pop          = o_valid && i_ready;
    assign o_cmd        = r_mem[r_rd_ptr];
    assign o_stat.level = r_count;

    // advance pointers and level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + fpdl_pkg::QPTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + fpdl_pkg::QPTR_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + fpdl_pkg::QCNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - fpdl_pkg::QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

>>> design/fpdl_back.sv
// ----------------------------------------------------------------------------
// fpdl_back
// Execution engine: owns the weight, bias and activation stores, runs the
// MAC sequencer for a start and drives the result output register.
// ----------------------------------------------------------------------------
module fpdl_back (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  fpdl_pkg::t_cfg                         i_cfg,
    input  logic                                   i_cmd_valid,
    output logic                                   o_cmd_ready,
    input  fpdl_pkg::t_cmd                         i_cmd,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic [fpdl_pkg::NEU_W-1:0]             o_neuron,
    output logic signed [fpdl_pkg::DATA_WIDTH-1:0] o_result,
    output logic                                   o_last,
    output fpdl_pkg::t_back_stat                   o_stat
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_BIAS = 2'd1;
    localparam logic [1:0] ST_MAC  = 2'd2;
    localparam logic [1:0] ST_SAT  = 2'd3;

    localparam int DW = fpdl_pkg::DATA_WIDTH;
    localparam int AW = fpdl_pkg::ACC_W;
    localparam int PW = fpdl_pkg::PROD_W;

    // stores
    logic signed [DW-1:0] mem_w [0:fpdl_pkg::W_DEPTH-1];
    logic signed [DW-1:0] mem_a [0:fpdl_pkg::MAX_INPUTS-1];
    logic signed [DW-1:0] r_bias [0:fpdl_pkg::MAX_OUTPUTS-1];

    logic [1:0]                    r_state;
    logic [fpdl_pkg::NEU_W-1:0]    r_n;
    logic [fpdl_pkg::OUT_W-1:0]    r_no;
    logic [fpdl_pkg::IN_W-1:0]     r_ni;
    logic [fpdl_pkg::IN_W-1:0]     r_i;
    logic [fpdl_pkg::W_AW-1:0]     r_waddr;
    logic [fpdl_pkg::FRAC_W-1:0]   r_frac;
    logic                          r_relu;
    logic                          r_v1;
    logic                          r_v2;
    logic signed [DW-1:0]          r_w_rd;
    logic signed [DW-1:0]          r_a_rd;
    logic signed [PW-1:0]          r_prod;
    logic signed [AW-1:0]          r_acc;

    logic                          r_ov;
    logic [fpdl_pkg::NEU_W-1:0]    r_on;
    logic signed [DW-1:0]          r_or;
    logic                          r_ol;

    logic                          pop;
    logic                          is_start;
    logic                          issue;
    logic                          out_free;
    logic                          is_last;
    logic [fpdl_pkg::IN_W-1:0]     ni_clamp;
    logic [fpdl_pkg::OUT_W-1:0]    no_clamp;
    logic signed [AW-1:0]          bias_ext;
    logic signed [AW-1:0]          shifted;
    logic signed [DW-1:0]          sat_val;

    assign is_start    = (i_cmd.op == fpdl_pkg::OP_START);
    // a start waits for the output register to drain
    assign pop         = (r_state == ST_IDLE) && i_cmd_valid && (!is_start || !r_ov);
    assign o_cmd_ready = pop;
    assign issue       = (r_state == ST_MAC) && (r_i != r_ni);
    assign out_free    = !r_ov || i_ready;
    assign is_last     = ({1'b0, r_n} + fpdl_pkg::OUT_W'(1)) == r_no;

    assign o_valid     = r_ov;
    assign o_neuron    = r_on;
    assign o_result    = r_or;
    assign o_last      = r_ol;
    assign o_stat.no   = r_no;
    assign o_stat.relu = r_relu;

    // clamp sizes to the store dimensions
    always_comb begin
        if (i_cfg.in_size > fpdl_pkg::IN_W'(fpdl_pkg::MAX_INPUTS)) begin
            ni_clamp = fpdl_pkg::IN_W'(fpdl_pkg::MAX_INPUTS);
        end else begin
            ni_clamp = i_cfg.in_size;
        end
        if (i_cfg.out_size > fpdl_pkg::OUT_W'(fpdl_pkg::MAX_OUTPUTS)) begin
            no_clamp = fpdl_pkg::OUT_W'(fpdl_pkg::MAX_OUTPUTS);
        end else begin
            no_clamp = i_cfg.out_size;
        end
    end

    // bias aligned to the accumulator's fraction point
    assign bias_ext = $signed({{(AW-DW){r_bias[r_n][DW-1]}}, r_bias[r_n]}) <<< r_frac;

    // floor shift, saturate, optional ReLU
    assign shifted = r_acc >>> r_frac;
    always_comb begin
        if (shifted > fpdl_pkg::SAT_MAX) begin
            sat_val = fpdl_pkg::SAT_MAX[DW-1:0];
        end else if (shifted < fpdl_pkg::SAT_MIN) begin
            sat_val = fpdl_pkg::SAT_MIN[DW-1:0];
        end else begin
            sat_val = shifted[DW-1:0];
        end
        if (r_relu && sat_val[DW-1]) begin
            sat_val = '0;
        end
    end

    // store writes and registered reads
    always_ff @(posedge i_clk) begin
        if (pop && (i_cmd.op == fpdl_pkg::OP_LD_W)) begin
            mem_w[i_cmd.index] <= i_cmd.value;
        end
        r_w_rd <= mem_w[r_waddr];
    end

    always_ff @(posedge i_clk) begin
        if (pop && (i_cmd.op == fpdl_pkg::OP_LD_A)) begin
            mem_a[i_cmd.index[fpdl_pkg::ACT_AW-1:0]] <= i_cmd.value;
        end
        r_a_rd <= mem_a[r_i[fpdl_pkg::ACT_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (pop && (i_cmd.op == fpdl_pkg::OP_LD_B)) begin
            r_bias[i_cmd.index[fpdl_pkg::BIAS_AW-1:0]] <= i_cmd.value;
        end
    end

    // multiply stage
    always_ff @(posedge i_clk) begin
        r_prod <= r_w_rd * r_a_rd;
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_n     <= '0;
            r_no    <= '0;
            r_ni    <= '0;
            r_i     <= '0;
            r_waddr <= '0;
            r_frac  <= '0;
            r_relu  <= 1'b0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_acc   <= '0;
        end else begin
            r_v1 <= issue;
            r_v2 <= r_v1;
            if (r_v2) begin
                r_acc <= r_acc + $signed({{(AW-PW){r_prod[PW-1]}}, r_prod});
            end
            case (r_state)
                ST_IDLE: begin
                    if (pop && is_start) begin
                        r_ni    <= ni_clamp;
                        r_no    <= no_clamp;
                        r_frac  <= i_cfg.frac_bits;
                        r_relu  <= i_cfg.relu;
                        r_n     <= '0;
                        r_waddr <= '0;
                        r_state <= (no_clamp == '0) ? ST_IDLE : ST_BIAS;
                    end
                end
                ST_BIAS: begin
                    r_acc   <= bias_ext;
                    r_i     <= '0;
                    r_state <= ST_MAC;
                end
                ST_MAC: begin
                    if (issue) begin
                        r_i     <= r_i + fpdl_pkg::IN_W'(1);
                        r_waddr <= r_waddr + fpdl_pkg::W_AW'(1);
                    end else if (!r_v1 && !r_v2) begin
                        r_state <= ST_SAT;
                    end
                end
                ST_SAT: begin
                    if (out_free) begin
                        if (is_last) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_n     <= r_n + fpdl_pkg::NEU_W'(1);
                            r_state <= ST_BIAS;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // result output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if ((r_state == ST_SAT) && out_free) begin
            r_ov <= 1'b1;
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_SAT) && out_free) begin
            r_on <= r_n;
            r_or <= sat_val;
            r_ol <= is_last;
        end
    end

endmodule
